@@ hw/rtl/csl_pkg.sv @@
package csl_pkg;

   // list geometry
   localparam int DEPTH     = 16;
   localparam int WORD_BITS = 32;
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   // command codes of a request transaction
   typedef enum logic [2:0] {
      CMD_START   = 3'd0,
      CMD_ADVANCE = 3'd1,
      CMD_INSERT  = 3'd2,
      CMD_ATTACH  = 3'd3,
      CMD_REMOVE  = 3'd4,
      CMD_READ    = 3'd5
   } cmd_type;

   // error codes of a response transaction
   typedef enum logic [1:0] {
      ERR_OK         = 2'd0,
      ERR_FULL       = 2'd1,
      ERR_NO_CURRENT = 2'd2
   } err_type;

   // what one cell does at the next edge
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_LEFT,
      CELL_FROM_RIGHT
   } cell_op_type;

   // list status handed from the controller to the top level
   typedef struct packed {
      logic [CNT_BITS-1:0] cursor;
      logic [CNT_BITS-1:0] count;
      err_type             err;
   } status_type;

   // top level sequencing
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SEND
   } state_type;

endpackage

@@ hw/rtl/csl_cell.sv @@
module csl_cell (
   input  logic                           clock,
   input  csl_pkg::cell_op_type           op,
   input  logic [csl_pkg::WORD_BITS-1:0]  load_word,
   input  logic [csl_pkg::WORD_BITS-1:0]  left_word,
   input  logic [csl_pkg::WORD_BITS-1:0]  right_word,
   output logic [csl_pkg::WORD_BITS-1:0]  word
);

   logic [csl_pkg::WORD_BITS-1:0] word_ff;
   logic [csl_pkg::WORD_BITS-1:0] word_in;

   // pick the next content of this position
   always_comb begin
      case (op)
         csl_pkg::CELL_LOAD:       word_in = load_word;
         csl_pkg::CELL_FROM_LEFT:  word_in = left_word;
         csl_pkg::CELL_FROM_RIGHT: word_in = right_word;
         default:                  word_in = word_ff;
      endcase
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

@@ hw/rtl/csl_ctrl.sv @@
module csl_ctrl (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          apply,
   input  logic [2:0]                                    command,
   output csl_pkg::cell_op_type [csl_pkg::DEPTH-1:0]     cell_op,
   output csl_pkg::status_type                           status
);

   logic [csl_pkg::CNT_BITS-1:0] cursor_ff, cursor_in;
   logic [csl_pkg::CNT_BITS-1:0] count_ff, count_in;
   csl_pkg::err_type             err_ff, err_in;
   logic [csl_pkg::CNT_BITS-1:0] pos;
   logic                         has_cur;
   logic                         full;
   logic                         grow;
   logic                         shrink;

   assign has_cur = cursor_ff < count_ff;
   assign full    = count_ff == csl_pkg::CNT_BITS'(csl_pkg::DEPTH);

   // decode the command into cursor, count and error updates
   always_comb begin
      cursor_in = cursor_ff;
      count_in  = count_ff;
      err_in    = csl_pkg::ERR_OK;
      pos       = cursor_ff;
      grow      = 1'b0;
      shrink    = 1'b0;
      case (command)
         csl_pkg::CMD_START: begin
            cursor_in = '0;
         end
         csl_pkg::CMD_ADVANCE: begin
            if (has_cur) cursor_in = cursor_ff + 1'b1;
            else err_in = csl_pkg::ERR_NO_CURRENT;
         end
         csl_pkg::CMD_INSERT: begin
            pos = has_cur ? cursor_ff : '0;
            if (full) err_in = csl_pkg::ERR_FULL;
            else begin
               grow      = 1'b1;
               cursor_in = pos;
               count_in  = count_ff + 1'b1;
            end
         end
         csl_pkg::CMD_ATTACH: begin
            pos = has_cur ? cursor_ff + 1'b1 : count_ff;
            if (full) err_in = csl_pkg::ERR_FULL;
            else begin
               grow      = 1'b1;
               cursor_in = pos;
               count_in  = count_ff + 1'b1;
            end
         end
         csl_pkg::CMD_REMOVE: begin
            if (has_cur) begin
               shrink   = 1'b1;
               count_in = count_ff - 1'b1;
            end else err_in = csl_pkg::ERR_NO_CURRENT;
         end
         default: begin
         end
      endcase
   end

   // per-cell moves: open a gap at pos, or close the gap at the cursor
   always_comb begin
      for (int i = 0; i < csl_pkg::DEPTH; i++) begin
         cell_op[i] = csl_pkg::CELL_HOLD;
         if (apply && grow) begin
            if (csl_pkg::CNT_BITS'(i) == pos)
               cell_op[i] = csl_pkg::CELL_LOAD;
            else if (csl_pkg::CNT_BITS'(i) > pos && csl_pkg::CNT_BITS'(i) <= count_ff)
               cell_op[i] = csl_pkg::CELL_FROM_LEFT;
         end else if (apply && shrink) begin
            if (csl_pkg::CNT_BITS'(i) >= cursor_ff
                && (csl_pkg::CNT_BITS'(i) + 1'b1) < count_ff)
               cell_op[i] = csl_pkg::CELL_FROM_RIGHT;
         end
      end
   end

   // list state
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         count_ff  <= '0;
         err_ff    <= csl_pkg::ERR_OK;
      end else if (apply) begin
         cursor_ff <= cursor_in;
         count_ff  <= count_in;
         err_ff    <= err_in;
      end
   end

   assign status.cursor = cursor_ff;
   assign status.count  = count_ff;
   assign status.err    = err_ff;

   // cursor never passes the end of the list
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= count_ff)
      else $error("cursor beyond count");

   // count never exceeds the number of cells
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= csl_pkg::CNT_BITS'(csl_pkg::DEPTH))
      else $error("count beyond depth");

   // a refused transaction leaves the list untouched
   a_refused_holds: assert property (@(posedge clock) disable iff (reset)
      apply && err_in != csl_pkg::ERR_OK
      |=> count_ff == $past(count_ff) && cursor_ff == $past(cursor_ff))
      else $error("refused command changed the list");

   // a full list is only reported when it really is full
   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      apply && err_in == csl_pkg::ERR_FULL |-> full)
      else $error("full flagged on a list with room");

endmodule

@@ hw/rtl/cursor_sequence_list.sv @@
// channel | dir | tdata fields (lsb first)                              | width
// req     | in  | command[2:0], value[34:3], zero pad[39:35]             | 40
// rsp     | out | current_value[31:0], has_current[32], count[37:33],    | 40
//         |     | error[39:38]                                           |
//
// in each transaction the list cells shift on the accept edge,
// and the word under the cursor is picked into the response register the cycle after.
// a new request is taken in the same cycle that the pending response is taken.
// reset (synchronous, active high) empties the list and drops any pending response.
// a stalled response holds its data; requests wait meanwhile.
module cursor_sequence_list (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // command[2:0], value[34:3]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // current_value[31:0], has_current, count[4:0], error[1:0]
);

   csl_pkg::state_type                          state_ff, state_in;
   csl_pkg::cell_op_type [csl_pkg::DEPTH-1:0]   cell_op;
   csl_pkg::status_type                         status;
   logic [csl_pkg::WORD_BITS-1:0]               cell_word [csl_pkg::DEPTH];
   logic [csl_pkg::WORD_BITS-1:0]               load_word;
   logic                                        req_take;
   logic                                        rsp_take;
   logic                                        out_has;
   logic [31:0]                                 out_word;
   logic [39:0]                                 rsp_data_ff, rsp_data_in;

   assign req_take  = req_tvalid && req_tready;
   assign rsp_take  = rsp_tvalid && rsp_tready;
   assign load_word = csl_pkg::WORD_BITS'(req_tdata[34:3]);

   // cursor, count and shift control
   csl_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .apply   (req_take),
      .command (req_tdata[2:0]),
      .cell_op (cell_op),
      .status  (status)
   );

   // row of cells, each talks to its neighbours; the two end cells see zero beyond the row
   for (genvar i = 0; i < csl_pkg::DEPTH; i++) begin : g_cell
      logic [csl_pkg::WORD_BITS-1:0] left_word;
      logic [csl_pkg::WORD_BITS-1:0] right_word;
      if (i == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_left
         assign left_word = cell_word[i-1];
      end
      if (i == csl_pkg::DEPTH - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_right
         assign right_word = cell_word[i+1];
      end
      csl_cell u_cell (
         .clock      (clock),
         .op         (cell_op[i]),
         .load_word  (load_word),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (cell_word[i])
      );
   end

   // word under the cursor
   assign out_has  = status.cursor < status.count;
   assign out_word = out_has
      ? 32'(cell_word[status.cursor[csl_pkg::ADDR_BITS-1:0]]) : 32'd0;

   // sequencing and handshake
   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         csl_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = csl_pkg::ST_READ;
         end
         csl_pkg::ST_READ: begin
            rsp_data_in = {status.err, 5'(status.count), out_has, out_word};
            state_in    = csl_pkg::ST_SEND;
         end
         csl_pkg::ST_SEND: begin
            rsp_tvalid = 1'b1;
            req_tready = rsp_tready;
            if (rsp_tready) state_in = req_tvalid ? csl_pkg::ST_READ : csl_pkg::ST_IDLE;
         end
         default: state_in = csl_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= csl_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tdata = rsp_data_ff;

   // a request is only taken when no response would be overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_take |-> !rsp_tvalid || rsp_take)
      else $error("request taken over a pending response");

   // every accepted request shows a response once the READ state has passed
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_take |=> ##1 rsp_tvalid)
      else $error("response missing after request");

   // a stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

endmodule

@@ tb/cursor_sequence_list_tb.sv @@
`timescale 1ns / 1ps

module cursor_sequence_list_tb;

   // spare command codes, handled as read only
   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;

   localparam int ITEMS_PER_PHASE = 400;
   localparam int STALL_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 20;

   // stimulus burst shapes
   typedef enum int {
      BURST_FILL,
      BURST_DRAIN,
      BURST_WALK,
      BURST_MIXED,
      BURST_SPARE,
      BURST_EMPTY_OUT
   } burst_kind_type;

   typedef struct packed {
      logic [2:0]                    op;
      logic [csl_pkg::WORD_BITS-1:0] word;
   } list_request_type;

   typedef struct packed {
      logic [csl_pkg::WORD_BITS-1:0] current_value;
      logic                          has_current;
      logic [csl_pkg::CNT_BITS-1:0]  count;
      csl_pkg::err_type              error;
   } cursor_report_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // command[2:0], value[34:3], zero pad[39:35]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // current_value[31:0], has_current, count[4:0], error[1:0]

   list_request_type  command_queue[$];
   cursor_report_type expected_reports[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int failures       = 0;
   int requests_taken = 0;
   int reports_seen   = 0;
   int full_refusals  = 0;
   int empty_refusals = 0;
   int times_full     = 0;
   int times_emptied  = 0;
   int quiet_cycles   = 0;

   // shadow copy of the list
   logic [csl_pkg::WORD_BITS-1:0] shadow_words[csl_pkg::DEPTH];
   int                            shadow_count  = 0;
   int                            shadow_cursor = 0;

   cursor_sequence_list dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // apply one command to the shadow list and queue the report it should give
   task automatic compute_cursor_report(input logic [2:0] op,
                                        input logic [csl_pkg::WORD_BITS-1:0] word);
      cursor_report_type r;
      logic              had_current;
      int                i;
      had_current = shadow_cursor < shadow_count;
      r.error = csl_pkg::ERR_OK;
      case (op)
         csl_pkg::CMD_START: begin
            shadow_cursor = 0;
         end
         csl_pkg::CMD_ADVANCE: begin
            if (had_current) shadow_cursor++;
            else r.error = csl_pkg::ERR_NO_CURRENT;
         end
         csl_pkg::CMD_INSERT: begin
            if (shadow_count >= csl_pkg::DEPTH) begin
               r.error = csl_pkg::ERR_FULL;
            end else begin
               if (!had_current) shadow_cursor = 0;
               for (i = shadow_count; i > shadow_cursor; i--)
                  shadow_words[i] = shadow_words[i-1];
               shadow_words[shadow_cursor] = word;
               shadow_count++;
            end
         end
         csl_pkg::CMD_ATTACH: begin
            if (shadow_count >= csl_pkg::DEPTH) begin
               r.error = csl_pkg::ERR_FULL;
            end else begin
               if (!had_current) begin
                  shadow_cursor = shadow_count;
               end else begin
                  for (i = shadow_count; i > shadow_cursor + 1; i--)
                     shadow_words[i] = shadow_words[i-1];
                  shadow_cursor++;
               end
               shadow_words[shadow_cursor] = word;
               shadow_count++;
            end
         end
         csl_pkg::CMD_REMOVE: begin
            if (!had_current) begin
               r.error = csl_pkg::ERR_NO_CURRENT;
            end else begin
               for (i = shadow_cursor + 1; i < shadow_count; i++)
                  shadow_words[i-1] = shadow_words[i];
               shadow_count--;
               if (shadow_count == 0) times_emptied++;
            end
         end
         default: ;
      endcase
      if (r.error == csl_pkg::ERR_FULL) full_refusals++;
      if (r.error == csl_pkg::ERR_NO_CURRENT) empty_refusals++;
      if (r.error == csl_pkg::ERR_OK && shadow_count == csl_pkg::DEPTH
          && (op == csl_pkg::CMD_INSERT || op == csl_pkg::CMD_ATTACH))
         times_full++;
      r.has_current   = shadow_cursor < shadow_count;
      r.current_value = r.has_current ? shadow_words[shadow_cursor] : '0;
      r.count         = shadow_count[csl_pkg::CNT_BITS-1:0];
      expected_reports.push_back(r);
   endtask

   // field by field comparison of one response
   task automatic check_report(input cursor_report_type want, input cursor_report_type got);
      if (got.current_value !== want.current_value) begin
         $display("%0t: current_value expected %h actual %h", $time,
                  want.current_value, got.current_value);
         failures++;
      end
      if (got.has_current !== want.has_current) begin
         $display("%0t: has_current expected %b actual %b", $time,
                  want.has_current, got.has_current);
         failures++;
      end
      if (got.count !== want.count) begin
         $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
         failures++;
      end
      if (got.error !== want.error) begin
         $display("%0t: error expected %0d actual %0d", $time, want.error, got.error);
         failures++;
      end
   endtask

   function automatic logic [csl_pkg::WORD_BITS-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 32'h1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // command choice, weighted by the burst shape
   function automatic logic [2:0] pick_op(input burst_kind_type kind);
      int roll;
      roll = $urandom_range(0, 99);
      case (kind)
         BURST_FILL: begin
            if (roll < 40) return csl_pkg::CMD_INSERT;
            if (roll < 80) return csl_pkg::CMD_ATTACH;
            if (roll < 90) return csl_pkg::CMD_ADVANCE;
            if (roll < 95) return csl_pkg::CMD_START;
            return csl_pkg::CMD_READ;
         end
         BURST_DRAIN: begin
            if (roll < 55) return csl_pkg::CMD_REMOVE;
            if (roll < 70) return csl_pkg::CMD_ADVANCE;
            if (roll < 85) return csl_pkg::CMD_START;
            if (roll < 90) return csl_pkg::CMD_READ;
            return csl_pkg::CMD_INSERT;
         end
         BURST_WALK: begin
            if (roll < 60) return csl_pkg::CMD_ADVANCE;
            if (roll < 75) return csl_pkg::CMD_READ;
            if (roll < 85) return csl_pkg::CMD_REMOVE;
            if (roll < 93) return csl_pkg::CMD_INSERT;
            return csl_pkg::CMD_ATTACH;
         end
         BURST_SPARE: begin
            if (roll < 40) return CMD_SPARE_A;
            if (roll < 80) return CMD_SPARE_B;
            return csl_pkg::CMD_READ;
         end
         BURST_EMPTY_OUT: begin
            return csl_pkg::CMD_REMOVE;
         end
         default: begin
            return 3'($urandom_range(csl_pkg::CMD_START, csl_pkg::CMD_READ));
         end
      endcase
   endfunction

   // queue one burst, returning how many of its items do real work
   function automatic int push_burst(input burst_kind_type kind);
      int               n;
      int               worked;
      list_request_type item;
      worked = 0;
      case (kind)
         BURST_SPARE:     n = $urandom_range(1, 3);
         BURST_EMPTY_OUT: n = csl_pkg::DEPTH + 2;
         default:         n = $urandom_range(4, 20);
      endcase
      if (kind == BURST_WALK || kind == BURST_EMPTY_OUT) begin
         command_queue.push_back('{op: csl_pkg::CMD_START, word: pick_word()});
         worked++;
      end
      repeat (n) begin
         item.op   = pick_op(kind);
         item.word = pick_word();
         command_queue.push_back(item);
         if (item.op != CMD_SPARE_A && item.op != CMD_SPARE_B) worked++;
      end
      return worked;
   endfunction

   function automatic burst_kind_type pick_burst();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) return BURST_FILL;
      if (roll < 55) return BURST_DRAIN;
      if (roll < 70) return BURST_WALK;
      if (roll < 90) return BURST_MIXED;
      if (roll < 95) return BURST_SPARE;
      return BURST_EMPTY_OUT;
   endfunction

   task automatic queue_item(input logic [2:0] op, input logic [csl_pkg::WORD_BITS-1:0] word);
      command_queue.push_back('{op: op, word: word});
   endtask

   // hold the sender back until every queued report has come home
   task automatic wait_for_drain();
      wait (command_queue.size() == 0 && !req_tvalid && expected_reports.size() == 0);
      @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin : driver
      list_request_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (command_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            item = command_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {5'b0, item.word, item.op};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(posedge clock) begin
      rsp_tready <= $urandom_range(0, 99) >= recv_stall_pct;
   end

   // monitor: check responses first, then predict for the request taken at this edge
   always @(posedge clock) begin : monitor
      cursor_report_type got;
      logic              moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            reports_seen++;
            got.current_value = rsp_tdata[31:0];
            got.has_current   = rsp_tdata[32];
            got.count         = rsp_tdata[37:33];
            got.error         = csl_pkg::err_type'(rsp_tdata[39:38]);
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected response, expected none actual %h", $time, rsp_tdata);
               failures++;
            end else begin
               check_report(expected_reports.pop_front(), got);
            end
         end
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            requests_taken++;
            compute_cursor_report(req_tdata[2:0], req_tdata[34:3]);
         end
      end
      // watchdog on a stuck handshake
      if (moved || reset) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("cursor_sequence_list test failed");
         $finish;
      end
   end

   initial begin : stimulus
      int        worked;
      int        phase;
      int        idle_plan[4];
      int        stall_plan[4];
      idle_plan  = '{0, 72, 0, 13};
      stall_plan = '{0, 0, 72, 13};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty list, refusals, no-current insert and attach, remove at the end
      queue_item(csl_pkg::CMD_READ, '0);
      queue_item(csl_pkg::CMD_ADVANCE, '1);
      queue_item(csl_pkg::CMD_REMOVE, '1);
      queue_item(csl_pkg::CMD_INSERT, 32'hFFFF_FFFF);
      queue_item(csl_pkg::CMD_ATTACH, 32'h0000_0000);
      queue_item(csl_pkg::CMD_ADVANCE, '0);
      queue_item(csl_pkg::CMD_ATTACH, 32'hA5A5_A5A5);
      queue_item(csl_pkg::CMD_REMOVE, '0);
      queue_item(csl_pkg::CMD_INSERT, 32'h5A5A_5A5A);
      queue_item(csl_pkg::CMD_ADVANCE, '0);
      queue_item(csl_pkg::CMD_INSERT, 32'h1234_5678);
      queue_item(csl_pkg::CMD_REMOVE, '0);
      queue_item(CMD_SPARE_A, '1);
      queue_item(CMD_SPARE_B, '0);
      queue_item(csl_pkg::CMD_START, '0);
      // fill to the top, then both adds get refused
      repeat (csl_pkg::DEPTH - 3) queue_item(csl_pkg::CMD_ATTACH, pick_word());
      queue_item(csl_pkg::CMD_INSERT, '1);
      queue_item(csl_pkg::CMD_ATTACH, '1);
      wait_for_drain();

      // random bursts under each idling pattern
      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct  <= idle_plan[phase];
         recv_stall_pct <= stall_plan[phase];
         worked = 0;
         while (worked < ITEMS_PER_PHASE) worked += push_burst(pick_burst());
         wait_for_drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_reports.size() != 0) begin
         $display("%0t: %0d responses still outstanding", $time, expected_reports.size());
         failures++;
      end
      $display("run: %0d requests, %0d responses checked across four idling patterns",
               requests_taken, reports_seen);
      $display("list filled %0d times, emptied %0d times; %0d full and %0d no-current refusals",
               times_full, times_emptied, full_refusals, empty_refusals);
      if (failures == 0) begin
         $display("cursor_sequence_list test passed");
      end else begin
         $display("cursor_sequence_list test failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/csl_pkg.sv
hw/rtl/csl_cell.sv
hw/rtl/csl_ctrl.sv
hw/rtl/cursor_sequence_list.sv
tb/cursor_sequence_list_tb.sv
